// ----- hdl/p2cr_pkg.sv -----
// Package for the polar to cartesian radar converter: widths, the word type
// passed from cell to cell, and elaboration-time functions for the CORDIC constants.
// No dependencies.
package p2cr_pkg;

   localparam int P2CR_DATA_W       = 32;
   localparam int P2CR_XY_W         = 34;
   localparam int P2CR_Z_W          = 36;
   localparam int P2CR_ITER_DEFAULT = 20;
   localparam int P2CR_FRAC         = 30;

   localparam logic [63:0] P2CR_PI_Q60 = 64'h3243_F6A8_885A_308D;

   // pi, 2*pi and pi/2 in Q.32, rounded to nearest
   localparam logic signed [P2CR_Z_W-1:0] P2CR_PI =
      P2CR_Z_W'((P2CR_PI_Q60 + (64'd1 << 27)) >> 28);
   localparam logic signed [P2CR_Z_W-1:0] P2CR_TWO_PI =
      P2CR_Z_W'((P2CR_PI_Q60 + (64'd1 << 26)) >> 27);
   localparam logic signed [P2CR_Z_W-1:0] P2CR_HALF_PI =
      P2CR_Z_W'((P2CR_PI_Q60 + (64'd1 << 28)) >> 29);

   typedef struct packed {
      logic signed [P2CR_DATA_W-1:0] rng;
      logic signed [P2CR_DATA_W-1:0] rate;
      logic signed [P2CR_XY_W-1:0]   x;
      logic signed [P2CR_XY_W-1:0]   y;
      logic signed [P2CR_Z_W-1:0]    z;
      logic                          neg;
   } p2cr_stage_type;

   // restoring divide, elaboration only
   function automatic logic [63:0] p2cr_udiv(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] p2cr_isqrt(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bt;
      v   = val;
      res = '0;
      bt  = 64'd1 << 62;
      for (int n = 0; n < 32; n++) begin
         if (bt > v) bt = bt >> 2;
      end
      for (int n = 0; n < 32; n++) begin
         if (bt != 64'd0) begin
            if (v >= res + bt) begin
               v   = v - (res + bt);
               res = (res >> 1) + bt;
            end else begin
               res = res >> 1;
            end
            bt = bt >> 2;
         end
      end
      return res;
   endfunction

   // atan(2^-idx) in Q.32 from a Taylor series in Q.62
   function automatic logic [63:0] p2cr_atan_q32(input int idx);
      logic [63:0] sum;
      logic [63:0] term;
      int          e;
      sum = '0;
      if (idx <= 0) return (P2CR_PI_Q60 + (64'd1 << 29)) >> 30;
      if (idx >= 62) return 64'd0;
      for (int k = 0; k < 64; k++) begin
         e = 62 - idx * (2 * k + 1);
         if (e >= 0) begin
            term = p2cr_udiv(64'd1 << e, 64'(2 * k + 1));
            if ((k % 2) == 0) sum = sum + term;
            else sum = sum - term;
         end
      end
      return (sum + (64'd1 << 29)) >> 30;
   endfunction

   // CORDIC gain correction in Q.30
   function automatic logic [63:0] p2cr_gain_q30(input int iters);
      logic [63:0] p;
      logic [63:0] s;
      p = 64'd1 << 60;
      for (int i = 0; i < iters; i++) begin
         p = p + (p >> (2 * i));
      end
      s = p2cr_isqrt(p);
      if (s == 64'd0) s = 64'd1;
      return p2cr_udiv((64'd1 << 60) + (s >> 1), s);
   endfunction

endpackage

// ----- hdl/p2cr_prep.sv -----
// Front of the converter: registers a measurement, folds the bearing into
// [-pi/2, pi/2] over two stages and seeds the CORDIC. Depends on p2cr_pkg.
module p2cr_prep #(
   parameter int ITERATIONS = p2cr_pkg::P2CR_ITER_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      up_valid,
   output logic                                      up_ready,
   input  logic signed [p2cr_pkg::P2CR_DATA_W-1:0]   range_m,
   input  logic signed [p2cr_pkg::P2CR_DATA_W-1:0]   bearing,
   input  logic signed [p2cr_pkg::P2CR_DATA_W-1:0]   range_rate,
   output logic                                      dn_valid,
   input  logic                                      dn_ready,
   output p2cr_pkg::p2cr_stage_type                  dn_data
);
   import p2cr_pkg::*;

   localparam logic signed [P2CR_XY_W-1:0] GAIN = P2CR_XY_W'(p2cr_gain_q30(ITERATIONS));

   p2cr_stage_type a_ff, a_in, b_ff, b_in;
   logic           a_valid_ff, b_valid_ff;
   logic           a_ready, b_ready;
   logic signed [P2CR_Z_W-1:0] z_raw;

   assign b_ready  = !b_valid_ff || dn_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign up_ready = a_ready;

   // fold once by 2*pi
   always_comb begin
      z_raw     = $signed({bearing, 4'b0000});
      a_in      = '0;
      a_in.rng  = range_m;
      a_in.rate = range_rate;
      a_in.x    = GAIN;
      a_in.y    = '0;
      a_in.neg  = 1'b0;
      if (z_raw > P2CR_PI) a_in.z = z_raw - P2CR_TWO_PI;
      else if (z_raw < -P2CR_PI) a_in.z = z_raw + P2CR_TWO_PI;
      else a_in.z = z_raw;
   end

   // fold by pi, negating both outputs later
   always_comb begin
      b_in = a_ff;
      if (a_ff.z > P2CR_HALF_PI) begin
         b_in.z   = a_ff.z - P2CR_PI;
         b_in.neg = 1'b1;
      end else if (a_ff.z < -P2CR_HALF_PI) begin
         b_in.z   = a_ff.z + P2CR_PI;
         b_in.neg = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= up_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && up_valid) a_ff <= a_in;
      if (b_ready && a_valid_ff) b_ff <= b_in;
   end

   assign dn_valid = b_valid_ff;
   assign dn_data  = b_ff;

endmodule

// ----- hdl/p2cr_cell.sv -----
// One CORDIC rotation step with its own register and handshake; the cells
// are chained to form the rotation pipeline. Depends on p2cr_pkg.
module p2cr_cell #(
   parameter int IDX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      up_valid,
   output logic                      up_ready,
   input  p2cr_pkg::p2cr_stage_type  up_data,
   output logic                      dn_valid,
   input  logic                      dn_ready,
   output p2cr_pkg::p2cr_stage_type  dn_data
);
   import p2cr_pkg::*;

   localparam logic signed [P2CR_Z_W-1:0] ATAN = P2CR_Z_W'(p2cr_atan_q32(IDX));

   p2cr_stage_type d_ff, d_in;
   logic           valid_ff;
   logic signed [P2CR_XY_W-1:0] x_cur, y_cur, dx, dy;

   assign up_ready = !valid_ff || dn_ready;
   assign x_cur    = up_data.x;
   assign y_cur    = up_data.y;
   assign dx       = y_cur >>> IDX;
   assign dy       = x_cur >>> IDX;

   // rotate toward zero residual angle
   always_comb begin
      d_in = up_data;
      if (!up_data.z[P2CR_Z_W-1]) begin
         d_in.x = x_cur - dx;
         d_in.y = y_cur + dy;
         d_in.z = up_data.z - ATAN;
      end else begin
         d_in.x = x_cur + dx;
         d_in.y = y_cur - dy;
         d_in.z = up_data.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (up_ready) valid_ff <= up_valid;
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) d_ff <= d_in;
   end

   assign dn_valid = valid_ff;
   assign dn_data  = d_ff;

endmodule

// ----- hdl/p2cr_mul.sv -----
// Back of the converter: applies the fold sign, forms the four products,
// then rounds and saturates into the output register. Depends on p2cr_pkg.
module p2cr_mul (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     up_valid,
   output logic                                     up_ready,
   input  p2cr_pkg::p2cr_stage_type                 up_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [p2cr_pkg::P2CR_DATA_W-1:0]  rsp_pos_x,
   output logic signed [p2cr_pkg::P2CR_DATA_W-1:0]  rsp_pos_y,
   output logic signed [p2cr_pkg::P2CR_DATA_W-1:0]  rsp_vel_x,
   output logic signed [p2cr_pkg::P2CR_DATA_W-1:0]  rsp_vel_y
);
   import p2cr_pkg::*;

   localparam int PROD_W = 2 * P2CR_DATA_W;

   function automatic logic signed [P2CR_DATA_W-1:0] round_sat(
      input logic signed [PROD_W-1:0] p
   );
      logic signed [PROD_W:0] r;
      r = ($signed({p[PROD_W-1], p}) + $signed((PROD_W + 1)'(1) << (P2CR_FRAC - 1)))
          >>> P2CR_FRAC;
      if (r > $signed((PROD_W + 1)'({1'b0, {(P2CR_DATA_W - 1){1'b1}}})))
         return {1'b0, {(P2CR_DATA_W - 1){1'b1}}};
      if (r < -$signed((PROD_W + 1)'({1'b1, {(P2CR_DATA_W - 1){1'b0}}})))
         return {1'b1, {(P2CR_DATA_W - 1){1'b0}}};
      return r[P2CR_DATA_W-1:0];
   endfunction

   logic signed [P2CR_XY_W-1:0]   c_wide, s_wide;
   logic signed [P2CR_DATA_W-1:0] c_trig, s_trig;
   logic signed [PROD_W-1:0]      px_in, py_in, vx_in, vy_in;
   logic signed [PROD_W-1:0]      px_ff, py_ff, vx_ff, vy_ff;
   logic signed [P2CR_DATA_W-1:0] pos_x_ff, pos_y_ff, vel_x_ff, vel_y_ff;
   logic                          m_valid_ff, r_valid_ff;
   logic                          m_ready, r_ready;

   assign r_ready  = !r_valid_ff || rsp_ready;
   assign m_ready  = !m_valid_ff || r_ready;
   assign up_ready = m_ready;

   assign c_wide = up_data.neg ? -up_data.x : up_data.x;
   assign s_wide = up_data.neg ? -up_data.y : up_data.y;
   assign c_trig = c_wide[P2CR_DATA_W-1:0];
   assign s_trig = s_wide[P2CR_DATA_W-1:0];

   assign px_in = up_data.rng  * c_trig;
   assign py_in = up_data.rng  * s_trig;
   assign vx_in = up_data.rate * c_trig;
   assign vy_in = up_data.rate * s_trig;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else begin
         if (m_ready) m_valid_ff <= up_valid;
         if (r_ready) r_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (m_ready && up_valid) begin
         px_ff <= px_in;
         py_ff <= py_in;
         vx_ff <= vx_in;
         vy_ff <= vy_in;
      end
      if (r_ready && m_valid_ff) begin
         pos_x_ff <= round_sat(px_ff);
         pos_y_ff <= round_sat(py_ff);
         vel_x_ff <= round_sat(vx_ff);
         vel_y_ff <= round_sat(vy_ff);
      end
   end

   assign rsp_valid = r_valid_ff;
   assign rsp_pos_x = pos_x_ff;
   assign rsp_pos_y = pos_y_ff;
   assign rsp_vel_x = vel_x_ff;
   assign rsp_vel_y = vel_y_ff;

endmodule

// ----- hdl/polar_to_cartesian_radar.sv -----
// Channel  Ports                                        Direction  Handshake
// req      req_range_m, req_bearing, req_range_rate     in         req_valid / req_ready
// rsp      rsp_pos_x, rsp_pos_y, rsp_vel_x, rsp_vel_y   out        rsp_valid / rsp_ready
//
// Takes one measurement per clock unless a waiting result backs up the chain; it has two fold stages,
// one cell per CORDIC step, one multiply and one rounding stage.
// Every stage has its own valid bit and ready, so bubbles close up and a waiting
// result stalls the chain one stage at a time. Reset clears the valid bits only.
// Top level of the polar to cartesian radar converter; depends on p2cr_pkg,
// p2cr_prep, p2cr_cell and p2cr_mul.
module polar_to_cartesian_radar #(
   parameter int CORDIC_ITERATIONS = p2cr_pkg::P2CR_ITER_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [p2cr_pkg::P2CR_DATA_W-1:0]  req_range_m,
   input  logic signed [p2cr_pkg::P2CR_DATA_W-1:0]  req_bearing,
   input  logic signed [p2cr_pkg::P2CR_DATA_W-1:0]  req_range_rate,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [p2cr_pkg::P2CR_DATA_W-1:0]  rsp_pos_x,
   output logic signed [p2cr_pkg::P2CR_DATA_W-1:0]  rsp_pos_y,
   output logic signed [p2cr_pkg::P2CR_DATA_W-1:0]  rsp_vel_x,
   output logic signed [p2cr_pkg::P2CR_DATA_W-1:0]  rsp_vel_y
);
   import p2cr_pkg::*;

   p2cr_stage_type                 stage_data [CORDIC_ITERATIONS+1];
   logic [CORDIC_ITERATIONS:0]     chain_valid;
   logic [CORDIC_ITERATIONS:0]     chain_ready;

   p2cr_prep #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_ready   (req_ready),
      .range_m    (req_range_m),
      .bearing    (req_bearing),
      .range_rate (req_range_rate),
      .dn_valid   (chain_valid[0]),
      .dn_ready   (chain_ready[0]),
      .dn_data    (stage_data[0])
   );

   for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cell
      p2cr_cell #(
         .IDX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[i]),
         .up_ready (chain_ready[i]),
         .up_data  (stage_data[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_ready (chain_ready[i+1]),
         .dn_data  (stage_data[i+1])
      );
   end

   p2cr_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (chain_valid[CORDIC_ITERATIONS]),
      .up_ready  (chain_ready[CORDIC_ITERATIONS]),
      .up_data   (stage_data[CORDIC_ITERATIONS]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_pos_x (rsp_pos_x),
      .rsp_pos_y (rsp_pos_y),
      .rsp_vel_x (rsp_vel_x),
      .rsp_vel_y (rsp_vel_y)
   );

`ifndef SYNTHESIS
   // input may only back up once every stage downstream holds a word
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> ((&chain_valid) && rsp_valid))
      else $error("req_ready low with an empty stage in the chain");

   // folded angle must lie within [-pi/2, pi/2]
   assert property (@(posedge clock) disable iff (reset)
      chain_valid[0] |-> ((stage_data[0].z <= P2CR_HALF_PI) &&
                          (stage_data[0].z >= -P2CR_HALF_PI)))
      else $error("folded bearing out of range");

   // last cell holds its word while the multiplier stalls
   assert property (@(posedge clock) disable iff (reset)
      (chain_valid[CORDIC_ITERATIONS] && !chain_ready[CORDIC_ITERATIONS]) |=>
      (chain_valid[CORDIC_ITERATIONS] && $stable(stage_data[CORDIC_ITERATIONS])))
      else $error("last cell lost a stalled word");
`endif

endmodule

// ----- tb/tb_polar_to_cartesian_radar.sv -----
// Self-checking testbench for polar_to_cartesian_radar: directed table, then random words,
// all results compared against a CORDIC predictor built into this file, or a fixed word for fixed rows.
// Depends on p2cr_pkg (port widths) and the polar_to_cartesian_radar RTL.
`timescale 1ns / 100ps

module tb_polar_to_cartesian_radar;
   import p2cr_pkg::*;

   localparam int ITERS          = 20;
   localparam int PERIOD         = 10;
   localparam int RESET_CYCLES   = 6;
   localparam int RANDOM_WORDS   = 600;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam bit [63:0] PI_SCALED_Q60 = 64'h3243_F6A8_885A_308D;
   // pi and pi/2 in Q3.28, truncated: the fold thresholds sit between these and the next LSB
   localparam logic signed [31:0] PI_Q28      = 32'sh3243_F6A8;
   localparam logic signed [31:0] HALF_PI_Q28 = 32'sh1921_FB54;
   localparam logic signed [31:0] TWO_PI_Q28  = 32'sh6487_ED51;
   localparam logic signed [31:0] MAX_Q       = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MIN_Q       = 32'sh8000_0000;
   localparam logic signed [31:0] ONE_Q16     = 32'sh0001_0000;

   // index 0..3: pos_x, pos_y, vel_x, vel_y
   typedef logic [3:0][P2CR_DATA_W-1:0] cart_type;

   typedef struct {
      logic signed [P2CR_DATA_W-1:0] rng;
      logic signed [P2CR_DATA_W-1:0] brg;
      logic signed [P2CR_DATA_W-1:0] rate;
      bit                            fixed;
      cart_type                      want;
   } meas_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [P2CR_DATA_W-1:0] req_range_m = '0;
   logic signed [P2CR_DATA_W-1:0] req_bearing = '0;
   logic signed [P2CR_DATA_W-1:0] req_range_rate = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [P2CR_DATA_W-1:0] rsp_pos_x;
   logic signed [P2CR_DATA_W-1:0] rsp_pos_y;
   logic signed [P2CR_DATA_W-1:0] rsp_vel_x;
   logic signed [P2CR_DATA_W-1:0] rsp_vel_y;

   cart_type     expected_xy [$];
   meas_row_type directed_rows [$];
   string        field_names [4] = '{"pos_x", "pos_y", "vel_x", "vel_y"};

   longint pi_q32;
   longint two_pi_q32;
   longint half_pi_q32;
   longint gain_k;
   longint atan_tab [ITERS];

   bit calm = 1'b0;
   int sent = 0;
   int checked = 0;
   int mismatches = 0;
   int idle_cycles = 0;

   polar_to_cartesian_radar #(
      .CORDIC_ITERATIONS(ITERS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_range_m    (req_range_m),
      .req_bearing    (req_bearing),
      .req_range_rate (req_range_rate),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pos_x      (rsp_pos_x),
      .rsp_pos_y      (rsp_pos_y),
      .rsp_vel_x      (rsp_vel_x),
      .rsp_vel_y      (rsp_vel_y)
   );

   always #(PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic longint pi_q(input int sh);
      return longint'((PI_SCALED_Q60 + (64'd1 << (sh - 1))) >> sh);
   endfunction

   // atan(2^-i) in Q.32: alternating series summed in Q.62
   function automatic longint atan_q32(input int i);
      bit [63:0] acc;
      bit [63:0] term;
      int        e;
      acc = '0;
      if (i == 0) return pi_q(30);
      for (int k = 0; k < 64; k++) begin
         e = 62 - i * (2 * k + 1);
         if (e >= 0) begin
            term = (64'd1 << e) / 64'(2 * k + 1);
            if (k % 2 == 0) acc = acc + term;
            else acc = acc - term;
         end
      end
      return longint'((acc + (64'd1 << 29)) >> 30);
   endfunction

   function automatic bit [63:0] root_floor(input bit [63:0] val);
      bit [63:0] rem;
      bit [63:0] res;
      bit [63:0] bt;
      rem = val;
      res = '0;
      bt  = 64'd1 << 62;
      while (bt > rem) bt = bt >> 2;
      while (bt != 0) begin
         if (rem >= res + bt) begin
            rem = rem - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   // 1/prod(sqrt(1 + 2^-2i)) in Q.30
   function automatic longint cordic_gain();
      bit [63:0] p;
      bit [63:0] s;
      p = 64'd1 << 60;
      for (int i = 0; i < ITERS; i++) p = p + (p >> (2 * i));
      s = root_floor(p);
      if (s == 0) s = 1;
      return longint'(((64'd1 << 60) + (s >> 1)) / s);
   endfunction

   // round a Q15.16 x Q.30 product back to Q15.16, ties up, then clamp
   function automatic logic [31:0] scale_sat(input longint a, input longint t);
      longint p;
      p = (a * t + (64'sd1 <<< 29)) >>> 30;
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[31:0];
   endfunction

   function automatic cart_type convert_meas(input logic signed [31:0] rng,
                                             input logic signed [31:0] brg,
                                             input logic signed [31:0] rate);
      longint   z;
      longint   x;
      longint   y;
      longint   dx;
      longint   dy;
      bit       neg;
      cart_type res;
      z   = longint'(brg) * 16;
      neg = 1'b0;
      if (z > pi_q32) z = z - two_pi_q32;
      else if (z < -pi_q32) z = z + two_pi_q32;
      // fold into the right half plane; flips the sign of both cos and sin
      if (z > half_pi_q32) begin
         z   = z - pi_q32;
         neg = 1'b1;
      end else if (z < -half_pi_q32) begin
         z   = z + pi_q32;
         neg = 1'b1;
      end
      x = gain_k;
      y = 0;
      for (int i = 0; i < ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_tab[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_tab[i];
         end
      end
      if (neg) begin
         x = -x;
         y = -y;
      end
      res[0] = scale_sat(longint'(rng), x);
      res[1] = scale_sat(longint'(rng), y);
      res[2] = scale_sat(longint'(rate), x);
      res[3] = scale_sat(longint'(rate), y);
      return res;
   endfunction

   // ---------------------------------------------------------------- driving

   function automatic meas_row_type mk_row(input logic signed [31:0] rng,
                                           input logic signed [31:0] brg,
                                           input logic signed [31:0] rate,
                                           input bit fixed, input cart_type want);
      meas_row_type row;
      row.rng   = rng;
      row.brg   = brg;
      row.rate  = rate;
      row.fixed = fixed;
      row.want  = want;
      return row;
   endfunction

   task automatic send_meas(input meas_row_type row);
      while (!calm && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_range_m    <= row.rng;
      req_bearing    <= row.brg;
      req_range_rate <= row.rate;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_xy.push_back(row.fixed ? row.want : convert_meas(row.rng, row.brg, row.rate));
      sent++;
   endtask

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 19);
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : rsp_check
      cart_type got;
      cart_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got[0] = rsp_pos_x;
         got[1] = rsp_pos_y;
         got[2] = rsp_vel_x;
         got[3] = rsp_vel_y;
         if (expected_xy.size() == 0) begin
            flag_mismatch($sformatf("unexpected result word %h", got));
         end else begin
            want = expected_xy.pop_front();
            for (int f = 0; f < 4; f++) begin
               if (got[f] !== want[f])
                  flag_mismatch($sformatf("result %0d %s got %h want %h",
                                          checked, field_names[f], got[f], want[f]));
            end
            checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                  WATCHDOG_LIMIT, expected_xy.size());
         $display("tb_polar_to_cartesian_radar NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      logic signed [31:0] r;
      logic signed [31:0] b;
      logic signed [31:0] v;
      int                 sel;

      pi_q32      = pi_q(28);
      two_pi_q32  = pi_q(27);
      half_pi_q32 = pi_q(29);
      gain_k      = cordic_gain();
      for (int i = 0; i < ITERS; i++) atan_tab[i] = atan_q32(i);

      // zero magnitude gives zero at any angle, then zero bearing at unit and full-scale magnitudes
      directed_rows.push_back(mk_row('0, '0, '0, 1'b1, '0));
      directed_rows.push_back(mk_row('0, MAX_Q, '0, 1'b1, '0));
      directed_rows.push_back(mk_row('0, MIN_Q, '0, 1'b1, '0));
      directed_rows.push_back(mk_row(ONE_Q16, '0, ONE_Q16, 1'b0, '0));
      directed_rows.push_back(mk_row(MAX_Q, '0, MIN_Q, 1'b0, '0));
      directed_rows.push_back(mk_row(MIN_Q, '0, MAX_Q, 1'b0, '0));
      // either side of the pi/2 and pi fold thresholds
      directed_rows.push_back(mk_row(MAX_Q, HALF_PI_Q28, MIN_Q, 1'b0, '0));
      directed_rows.push_back(mk_row(MAX_Q, HALF_PI_Q28 + 1, MIN_Q, 1'b0, '0));
      directed_rows.push_back(mk_row(MIN_Q, -HALF_PI_Q28, MAX_Q, 1'b0, '0));
      directed_rows.push_back(mk_row(MIN_Q, -HALF_PI_Q28 - 1, MAX_Q, 1'b0, '0));
      directed_rows.push_back(mk_row(MAX_Q, PI_Q28, MAX_Q, 1'b0, '0));
      directed_rows.push_back(mk_row(MAX_Q, PI_Q28 + 1, MAX_Q, 1'b0, '0));
      directed_rows.push_back(mk_row(MIN_Q, -PI_Q28, MIN_Q, 1'b0, '0));
      directed_rows.push_back(mk_row(MIN_Q, -PI_Q28 - 1, MIN_Q, 1'b0, '0));
      // bearing extremes need the 2*pi fold
      directed_rows.push_back(mk_row(MAX_Q, MAX_Q, MIN_Q, 1'b0, '0));
      directed_rows.push_back(mk_row(MIN_Q, MIN_Q, MAX_Q, 1'b0, '0));
      directed_rows.push_back(mk_row(ONE_Q16, TWO_PI_Q28, -ONE_Q16, 1'b0, '0));
      directed_rows.push_back(mk_row(-ONE_Q16, -TWO_PI_Q28, ONE_Q16, 1'b0, '0));
      directed_rows.push_back(mk_row(32'sd1, 32'sh0C90_FDAA, -32'sd1, 1'b0, '0));
      directed_rows.push_back(mk_row(32'sh5555_5555, 32'shFFFF_FFFF, 32'shAAAA_AAAA,
                                     1'b0, '0));
      directed_rows.push_back(mk_row(32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555,
                                     1'b0, '0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) send_meas(directed_rows[n]);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         calm = (n >= 250 && n < 400);
         r    = $urandom;
         b    = $urandom;
         v    = $urandom;
         sel  = $urandom_range(99);
         if (sel < 30) begin
            // realistic magnitudes: shrink range and rate
            r = $signed(r) >>> $urandom_range(30, 8);
            v = $signed(v) >>> $urandom_range(30, 8);
         end else if (sel < 45) begin
            // land within a few LSBs of a fold threshold
            case ($urandom_range(3))
               0: b = PI_Q28;
               1: b = -PI_Q28;
               2: b = HALF_PI_Q28;
               default: b = -HALF_PI_Q28;
            endcase
            b = b + $signed($urandom_range(8)) - 4;
         end else if (sel < 50) begin
            r = $urandom_range(1) ? MAX_Q : MIN_Q;
            v = $urandom_range(1) ? MAX_Q : MIN_Q;
         end
         send_meas(mk_row(r, b, v, 1'b0, '0));
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (expected_xy.size() != 0) @(posedge clock);
      repeat (ITERS + 10) @(posedge clock);

      $display("covered %0d measurements (%0d directed, %0d random), %0d results checked",
               sent, directed_rows.size(), RANDOM_WORDS, checked);
      $display("field mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("tb_polar_to_cartesian_radar OK");
      end else begin
         $display("tb_polar_to_cartesian_radar NOT OK");
      end
      $finish;
   end

endmodule
